[hw/rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold whenever the antecedent holds, same cycle
`define LVM_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("look-at view matrix check failed");

// property that must hold in the cycle after the antecedent
`define LVM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("look-at view matrix check failed");

`endif

[hw/rtl/lvm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_pkg
// shared widths, types, rounding and saturation helpers of the look-at view matrix unit
// ----------------------------------------------------------------------------
package lvm_pkg;

   localparam int FRAC     = 16;
   localparam int IN_W     = 24;
   localparam int AX_W     = 18;
   localparam int OFF_W    = 32;
   localparam int NW       = IN_W + FRAC + 4;
   localparam int SIDE_W   = 6 * IN_W;
   localparam int RW       = 48;
   localparam int NORM_MSB = 29;
   localparam int M_W      = NORM_MSB + 1;
   localparam int LEN_W    = NORM_MSB + 2;
   localparam int SQ_W     = 64;
   localparam int SQ_N     = SQ_W / 2;
   localparam int Q_W      = FRAC + 1;
   localparam int DIV_W    = NORM_MSB + 2 + FRAC;
   localparam int A_W      = 28;

   localparam logic signed [RW-1:0] ONE_RW  = RW'(1) <<< FRAC;
   localparam logic signed [RW-1:0] OFF_MAX = (RW'(1) <<< (OFF_W - 1)) - RW'(1);
   localparam logic signed [RW-1:0] OFF_MIN = -(RW'(1) <<< (OFF_W - 1));

   typedef enum logic [1:0] {
      ROW_RIGHT = 2'd0,
      ROW_UP    = 2'd1,
      ROW_VIEW  = 2'd2
   } lvm_row_type;

   typedef struct packed {
      logic              zero;
      logic [2:0]        neg;
      logic [SIDE_W-1:0] side;
   } lvm_tag_type;

   // divide by 2^FRAC, halves away from zero
   function automatic logic signed [RW-1:0] rnd(input logic signed [RW-1:0] x);
      logic [RW-1:0] mag;
      logic [RW-1:0] m;
      mag = x[RW-1] ? RW'(-x) : RW'(x);
      m   = (mag + (RW'(1) << (FRAC - 1))) >> FRAC;
      return x[RW-1] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [AX_W-1:0] clamp_unit(input logic signed [RW-1:0] x);
      logic signed [AX_W-1:0] r;
      if (x > ONE_RW) r = AX_W'(ONE_RW);
      else if (x < -ONE_RW) r = AX_W'(-ONE_RW);
      else r = AX_W'(x);
      return r;
   endfunction

   function automatic logic signed [OFF_W-1:0] sat_off(input logic signed [RW-1:0] x);
      logic signed [OFF_W-1:0] r;
      if (x > OFF_MAX) r = OFF_W'(OFF_MAX);
      else if (x < OFF_MIN) r = OFF_W'(OFF_MIN);
      else r = OFF_W'(x);
      return r;
   endfunction

endpackage

[hw/rtl/lvm_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_norm
// pipelined 3-vector normalizer: scale, sum of squares, root, three divides
// ----------------------------------------------------------------------------
module lvm_norm
   import lvm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic signed [NW-1:0]   in_vec [3],
   input  logic [SIDE_W-1:0]      in_side,
   output logic                   out_valid,
   output logic signed [AX_W-1:0] out_vec [3],
   output logic                   out_zero,
   output logic [SIDE_W-1:0]      out_side
);
   localparam int PW = $clog2(NW);
   localparam logic [Q_W-1:0] QONE = Q_W'(1) << FRAC;

   // magnitudes
   logic              v0_ff;
   lvm_tag_type       t0_ff, t0_in;
   logic [NW-1:0]     mag0_ff [3];
   logic [NW-1:0]     mag0_in [3];
   // leading one position
   logic              v1_ff;
   lvm_tag_type       t1_ff;
   logic [NW-1:0]     mag1_ff [3];
   logic [PW-1:0]     pos1_ff, pos1_in;
   logic [NW-1:0]     orv;
   // scaled
   logic              v2_ff;
   lvm_tag_type       t2_ff;
   logic [M_W-1:0]    m2_ff [3];
   logic [M_W-1:0]    m2_in [3];
   logic [PW-1:0]     sh;
   // squares
   logic              v3_ff;
   lvm_tag_type       t3_ff;
   logic [M_W-1:0]    m3_ff [3];
   logic [2*M_W-1:0]  sq3_ff [3];
   // root
   logic [SQ_N:0]     sqv_ff;
   lvm_tag_type       sqt_ff [SQ_N+1];
   lvm_tag_type       sqt_in [SQ_N+1];
   logic [M_W-1:0]    sqm_ff [SQ_N+1][3];
   logic [M_W-1:0]    sqm_in [SQ_N+1][3];
   logic [SQ_W-1:0]   sqx_ff [SQ_N+1];
   logic [SQ_W-1:0]   sqx_in [SQ_N+1];
   logic [SQ_W-1:0]   sqr_ff [SQ_N+1];
   logic [SQ_W-1:0]   sqr_in [SQ_N+1];
   logic [SQ_W-1:0]   sq_trial [SQ_N];
   // divides
   logic [Q_W:0]      dv_ff;
   lvm_tag_type       dt_ff [Q_W+1];
   lvm_tag_type       dt_in [Q_W+1];
   logic [LEN_W-1:0]  dlen_ff [Q_W+1];
   logic [LEN_W-1:0]  dlen_in [Q_W+1];
   logic [DIV_W-1:0]  drem_ff [Q_W+1][3];
   logic [DIV_W-1:0]  drem_in [Q_W+1][3];
   logic [Q_W-1:0]    dq_ff [Q_W+1][3];
   logic [Q_W-1:0]    dq_in [Q_W+1][3];
   logic [DIV_W-1:0]  dsub [Q_W];
   // result
   logic              ov_ff;
   logic signed [AX_W-1:0] ovec_ff [3];
   logic signed [AX_W-1:0] ovec_in [3];
   logic              oz_ff;
   logic [SIDE_W-1:0] oside_ff;
   logic [Q_W-1:0]    qc;

   always_comb begin
      for (int i = 0; i < 3; i++)
         mag0_in[i] = in_vec[i][NW-1] ? NW'(-in_vec[i]) : NW'(in_vec[i]);
      t0_in.zero = (in_vec[0] == '0) && (in_vec[1] == '0) && (in_vec[2] == '0);
      t0_in.neg  = {in_vec[2][NW-1], in_vec[1][NW-1], in_vec[0][NW-1]};
      t0_in.side = in_side;
   end

   always_comb begin
      orv     = mag0_ff[0] | mag0_ff[1] | mag0_ff[2];
      pos1_in = '0;
      for (int b = 0; b < NW; b++)
         if (orv[b]) pos1_in = PW'(b);
   end

   always_comb begin
      if (pos1_ff >= PW'(NORM_MSB)) begin
         sh = pos1_ff - PW'(NORM_MSB);
         for (int i = 0; i < 3; i++) m2_in[i] = M_W'(mag1_ff[i] >> sh);
      end else begin
         sh = PW'(NORM_MSB) - pos1_ff;
         for (int i = 0; i < 3; i++) m2_in[i] = M_W'(mag1_ff[i] << sh);
      end
   end

   // bit-pair square root, one step per stage
   always_comb begin
      sqx_in[0] = SQ_W'(sq3_ff[0]) + SQ_W'(sq3_ff[1]) + SQ_W'(sq3_ff[2]);
      sqr_in[0] = '0;
      sqm_in[0] = m3_ff;
      sqt_in[0] = t3_ff;
      for (int k = 0; k < SQ_N; k++) begin
         sq_trial[k] = sqr_ff[k] + (SQ_W'(1) << (SQ_W - 2 - 2 * k));
         if (sqx_ff[k] >= sq_trial[k]) begin
            sqx_in[k+1] = sqx_ff[k] - sq_trial[k];
            sqr_in[k+1] = (sqr_ff[k] >> 1) + (SQ_W'(1) << (SQ_W - 2 - 2 * k));
         end else begin
            sqx_in[k+1] = sqx_ff[k];
            sqr_in[k+1] = sqr_ff[k] >> 1;
         end
         sqm_in[k+1] = sqm_ff[k];
         sqt_in[k+1] = sqt_ff[k];
      end
   end

   // restoring divide, one quotient bit per stage, rounded by adding len/2
   always_comb begin
      dlen_in[0] = sqr_ff[SQ_N][LEN_W-1:0];
      dt_in[0]   = sqt_ff[SQ_N];
      for (int i = 0; i < 3; i++) begin
         drem_in[0][i] = (DIV_W'(sqm_ff[SQ_N][i]) << FRAC)
                       + DIV_W'(sqr_ff[SQ_N][LEN_W-1:1]);
         dq_in[0][i]   = '0;
      end
      for (int j = 0; j < Q_W; j++) begin
         dsub[j]      = DIV_W'(dlen_ff[j]) << (Q_W - 1 - j);
         dlen_in[j+1] = dlen_ff[j];
         dt_in[j+1]   = dt_ff[j];
         for (int i = 0; i < 3; i++) begin
            if (drem_ff[j][i] >= dsub[j]) begin
               drem_in[j+1][i] = drem_ff[j][i] - dsub[j];
               dq_in[j+1][i]   = dq_ff[j][i] | (Q_W'(1) << (Q_W - 1 - j));
            end else begin
               drem_in[j+1][i] = drem_ff[j][i];
               dq_in[j+1][i]   = dq_ff[j][i];
            end
         end
      end
   end

   always_comb begin
      qc = '0;
      for (int i = 0; i < 3; i++) begin
         qc = (dq_ff[Q_W][i] > QONE) ? QONE : dq_ff[Q_W][i];
         if (dt_ff[Q_W].zero) ovec_in[i] = '0;
         else if (dt_ff[Q_W].neg[i]) ovec_in[i] = -AX_W'(qc);
         else ovec_in[i] = AX_W'(qc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         sqv_ff <= '0;
         dv_ff  <= '0;
         ov_ff  <= 1'b0;
      end else if (en) begin
         v0_ff  <= in_valid;
         v1_ff  <= v0_ff;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         sqv_ff <= {sqv_ff[SQ_N-1:0], v3_ff};
         dv_ff  <= {dv_ff[Q_W-1:0], sqv_ff[SQ_N]};
         ov_ff  <= dv_ff[Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t0_ff   <= t0_in;
         mag0_ff <= mag0_in;
         t1_ff   <= t0_ff;
         mag1_ff <= mag0_ff;
         pos1_ff <= pos1_in;
         t2_ff   <= t1_ff;
         m2_ff   <= m2_in;
         t3_ff   <= t2_ff;
         m3_ff   <= m2_ff;
         for (int i = 0; i < 3; i++) sq3_ff[i] <= m2_ff[i] * m2_ff[i];
         sqx_ff  <= sqx_in;
         sqr_ff  <= sqr_in;
         sqm_ff  <= sqm_in;
         sqt_ff  <= sqt_in;
         dlen_ff <= dlen_in;
         drem_ff <= drem_in;
         dq_ff   <= dq_in;
         dt_ff   <= dt_in;
         ovec_ff <= ovec_in;
         oz_ff   <= dt_ff[Q_W].zero;
         oside_ff <= dt_ff[Q_W].side;
      end
   end

   assign out_valid = ov_ff;
   assign out_vec   = ovec_ff;
   assign out_zero  = oz_ff;
   assign out_side  = oside_ff;

endmodule

[hw/rtl/look_at_view_matrix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// builds the three rows of a look-at view matrix from eye, target and up
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake        payload
//   req      in         valid / stall    eye, target, up (9 x 24-bit Q8.16)
//   rsp      out        valid / stall    one matrix row: index, axis, offset
//
// one row leaves per cycle while rsp is not stalled, so at full rate a new word is
// taken for every three rows sent; that pace comes from the row serializer at the output
// the time until the first row appears is dominated by the two normalizer
// pipelines (32 root steps and 17 divide steps each)
// reset clears all valid bits and the serializer; payload registers hold junk
// the whole pipeline freezes while a finished word waits behind a full serializer
// that is not handing over its view row, and req_stall is high during the freeze
module look_at_view_matrix
   import lvm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [IN_W-1:0]  req_eye_x,
   input  logic signed [IN_W-1:0]  req_eye_y,
   input  logic signed [IN_W-1:0]  req_eye_z,
   input  logic signed [IN_W-1:0]  req_target_x,
   input  logic signed [IN_W-1:0]  req_target_y,
   input  logic signed [IN_W-1:0]  req_target_z,
   input  logic signed [IN_W-1:0]  req_upward_x,
   input  logic signed [IN_W-1:0]  req_upward_y,
   input  logic signed [IN_W-1:0]  req_upward_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_row_index,
   output logic signed [AX_W-1:0]  rsp_axis_x,
   output logic signed [AX_W-1:0]  rsp_axis_y,
   output logic signed [AX_W-1:0]  rsp_axis_z,
   output logic signed [OFF_W-1:0] rsp_offset,
   output logic                    rsp_degenerate,
   output logic                    rsp_last_row
);
   localparam int SIDE2_PAD = SIDE_W - 3 * IN_W - 3 * AX_W - 1;
   localparam int P1_W = IN_W + AX_W;
   localparam int P2_W = A_W + AX_W;
   localparam int PX_W = 2 * AX_W;

   // global advance: the whole pipe moves unless a finished word is blocked
   logic advance;
   logic rsp_take;

   // input stage: eye, up and target - eye
   logic                    a_v_ff;
   logic signed [IN_W-1:0]  a_eye_ff [3];
   logic signed [IN_W-1:0]  a_up_ff [3];
   logic signed [IN_W:0]    a_d_ff [3];
   logic signed [IN_W-1:0]  req_eye [3];
   logic signed [IN_W-1:0]  req_tgt [3];
   logic signed [IN_W-1:0]  req_up [3];

   // view direction normalizer
   logic signed [NW-1:0]    n1_in_vec [3];
   logic [SIDE_W-1:0]       n1_in_side;
   logic                    n1_valid;
   logic signed [AX_W-1:0]  n1_vec [3];
   logic                    n1_zero;
   logic [SIDE_W-1:0]       n1_side;

   // up . n products
   logic                    b1_v_ff, b1_z_ff;
   logic signed [IN_W-1:0]  b1_eye_ff [3];
   logic signed [IN_W-1:0]  b1_up_ff [3];
   logic signed [AX_W-1:0]  b1_n_ff [3];
   logic signed [P1_W-1:0]  b1_p_ff [3];
   // projection length a
   logic                    b2_v_ff, b2_z_ff;
   logic signed [IN_W-1:0]  b2_eye_ff [3];
   logic signed [IN_W-1:0]  b2_up_ff [3];
   logic signed [AX_W-1:0]  b2_n_ff [3];
   logic signed [A_W-1:0]   b2_a_ff;
   // a * n and up scaled
   logic                    b3_v_ff, b3_z_ff;
   logic signed [IN_W-1:0]  b3_eye_ff [3];
   logic signed [AX_W-1:0]  b3_n_ff [3];
   logic signed [P2_W-1:0]  b3_an_ff [3];
   logic signed [NW-1:0]    b3_ups_ff [3];
   // orthogonal up r
   logic                    b4_v_ff, b4_z_ff;
   logic signed [IN_W-1:0]  b4_eye_ff [3];
   logic signed [AX_W-1:0]  b4_n_ff [3];
   logic signed [NW-1:0]    b4_r_ff [3];

   // up axis normalizer
   logic [SIDE_W-1:0]       n2_in_side;
   logic                    n2_valid;
   logic signed [AX_W-1:0]  n2_vec [3];
   logic                    n2_zero;
   logic [SIDE_W-1:0]       n2_side;

   // cross and dot products
   logic                    c1_v_ff, c1_deg_ff;
   logic signed [IN_W-1:0]  c1_eye_ff [3];
   logic signed [AX_W-1:0]  c1_n_ff [3];
   logic signed [AX_W-1:0]  c1_v_vec_ff [3];
   logic signed [PX_W-1:0]  c1_cx_ff [6];
   logic signed [P1_W-1:0]  c1_pv_ff [3];
   logic signed [P1_W-1:0]  c1_pn_ff [3];
   logic signed [IN_W-1:0]  n2_eye [3];
   logic signed [AX_W-1:0]  n2_n [3];
   // right axis w, dot sums
   logic                    c2_v_ff, c2_deg_ff;
   logic signed [IN_W-1:0]  c2_eye_ff [3];
   logic signed [AX_W-1:0]  c2_n_ff [3];
   logic signed [AX_W-1:0]  c2_v_vec_ff [3];
   logic signed [AX_W-1:0]  c2_w_ff [3];
   logic signed [RW-1:0]    c2_accv_ff, c2_accn_ff;
   // w . eye products, two offsets
   logic                    c3_v_ff, c3_deg_ff;
   logic signed [AX_W-1:0]  c3_n_ff [3];
   logic signed [AX_W-1:0]  c3_v_vec_ff [3];
   logic signed [AX_W-1:0]  c3_w_ff [3];
   logic signed [P1_W-1:0]  c3_pw_ff [3];
   logic signed [OFF_W-1:0] c3_offv_ff, c3_offn_ff;
   // w . eye sum
   logic                    c4_v_ff, c4_deg_ff;
   logic signed [AX_W-1:0]  c4_n_ff [3];
   logic signed [AX_W-1:0]  c4_v_vec_ff [3];
   logic signed [AX_W-1:0]  c4_w_ff [3];
   logic signed [RW-1:0]    c4_accw_ff;
   logic signed [OFF_W-1:0] c4_offv_ff, c4_offn_ff;
   // last offset
   logic                    c5_v_ff, c5_deg_ff;
   logic signed [AX_W-1:0]  c5_n_ff [3];
   logic signed [AX_W-1:0]  c5_v_vec_ff [3];
   logic signed [AX_W-1:0]  c5_w_ff [3];
   logic signed [OFF_W-1:0] c5_offw_ff, c5_offv_ff, c5_offn_ff;

   // row serializer
   logic                    o_full_ff;
   lvm_row_type             o_row_ff;
   logic signed [AX_W-1:0]  o_ax_ff [3][3];
   logic signed [OFF_W-1:0] o_off_ff [3];
   logic                    o_deg_ff;
   logic                    o_load;

   assign rsp_take  = o_full_ff && !rsp_stall;
   assign advance   = !(c5_v_ff && o_full_ff && !(rsp_take && o_row_ff == ROW_VIEW));
   assign req_stall = !advance;
   assign o_load    = c5_v_ff && advance;

   assign req_eye = '{req_eye_x, req_eye_y, req_eye_z};
   assign req_tgt = '{req_target_x, req_target_y, req_target_z};
   assign req_up  = '{req_upward_x, req_upward_y, req_upward_z};

   // valid bits travel with the words
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff  <= 1'b0;
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
         b3_v_ff <= 1'b0;
         b4_v_ff <= 1'b0;
         c1_v_ff <= 1'b0;
         c2_v_ff <= 1'b0;
         c3_v_ff <= 1'b0;
         c4_v_ff <= 1'b0;
         c5_v_ff <= 1'b0;
      end else if (advance) begin
         a_v_ff  <= req_valid;
         b1_v_ff <= n1_valid;
         b2_v_ff <= b1_v_ff;
         b3_v_ff <= b2_v_ff;
         b4_v_ff <= b3_v_ff;
         c1_v_ff <= n2_valid;
         c2_v_ff <= c1_v_ff;
         c3_v_ff <= c2_v_ff;
         c4_v_ff <= c3_v_ff;
         c5_v_ff <= c4_v_ff;
      end
   end

   // input stage and view direction d = target - eye
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            a_eye_ff[i] <= req_eye[i];
            a_up_ff[i]  <= req_up[i];
            a_d_ff[i]   <= (IN_W+1)'(req_tgt[i]) - (IN_W+1)'(req_eye[i]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) n1_in_vec[i] = NW'(a_d_ff[i]);
      n1_in_side = {a_eye_ff[0], a_eye_ff[1], a_eye_ff[2],
                    a_up_ff[0], a_up_ff[1], a_up_ff[2]};
   end

   lvm_norm u_norm_view (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (a_v_ff),
      .in_vec    (n1_in_vec),
      .in_side   (n1_in_side),
      .out_valid (n1_valid),
      .out_vec   (n1_vec),
      .out_zero  (n1_zero),
      .out_side  (n1_side)
   );

   // gram-schmidt: r = up * 2^F - round(up . n) * n
   always_ff @(posedge clock) begin
      if (advance) begin
         b1_z_ff <= n1_zero;
         for (int i = 0; i < 3; i++) begin
            b1_eye_ff[i] <= $signed(n1_side[SIDE_W-1-IN_W*i -: IN_W]);
            b1_up_ff[i]  <= $signed(n1_side[SIDE_W-1-IN_W*(3+i) -: IN_W]);
            b1_n_ff[i]   <= n1_vec[i];
            b1_p_ff[i]   <= $signed(n1_side[SIDE_W-1-IN_W*(3+i) -: IN_W]) * n1_vec[i];
         end
         b2_z_ff   <= b1_z_ff;
         b2_eye_ff <= b1_eye_ff;
         b2_up_ff  <= b1_up_ff;
         b2_n_ff   <= b1_n_ff;
         b2_a_ff   <= A_W'(rnd(RW'(b1_p_ff[0]) + RW'(b1_p_ff[1]) + RW'(b1_p_ff[2])));
         b3_z_ff   <= b2_z_ff;
         b3_eye_ff <= b2_eye_ff;
         b3_n_ff   <= b2_n_ff;
         for (int i = 0; i < 3; i++) begin
            b3_an_ff[i]  <= b2_a_ff * b2_n_ff[i];
            b3_ups_ff[i] <= NW'(b2_up_ff[i]) <<< FRAC;
         end
         b4_z_ff   <= b3_z_ff;
         b4_eye_ff <= b3_eye_ff;
         b4_n_ff   <= b3_n_ff;
         for (int i = 0; i < 3; i++) b4_r_ff[i] <= b3_ups_ff[i] - NW'(b3_an_ff[i]);
      end
   end

   assign n2_in_side = {b4_eye_ff[0], b4_eye_ff[1], b4_eye_ff[2],
                        b4_n_ff[0], b4_n_ff[1], b4_n_ff[2],
                        b4_z_ff, {SIDE2_PAD{1'b0}}};

   lvm_norm u_norm_up (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (b4_v_ff),
      .in_vec    (b4_r_ff),
      .in_side   (n2_in_side),
      .out_valid (n2_valid),
      .out_vec   (n2_vec),
      .out_zero  (n2_zero),
      .out_side  (n2_side)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n2_eye[i] = $signed(n2_side[SIDE_W-1-IN_W*i -: IN_W]);
         n2_n[i]   = $signed(n2_side[SIDE_W-1-3*IN_W-AX_W*i -: AX_W]);
      end
   end

   // w = n x v, offsets from dot products with eye
   always_ff @(posedge clock) begin
      if (advance) begin
         c1_deg_ff   <= n2_zero || n2_side[SIDE_W-1-3*IN_W-3*AX_W];
         c1_eye_ff   <= n2_eye;
         c1_n_ff     <= n2_n;
         c1_v_vec_ff <= n2_vec;
         c1_cx_ff[0] <= n2_n[1] * n2_vec[2];
         c1_cx_ff[1] <= n2_n[2] * n2_vec[1];
         c1_cx_ff[2] <= n2_n[2] * n2_vec[0];
         c1_cx_ff[3] <= n2_n[0] * n2_vec[2];
         c1_cx_ff[4] <= n2_n[0] * n2_vec[1];
         c1_cx_ff[5] <= n2_n[1] * n2_vec[0];
         for (int i = 0; i < 3; i++) begin
            c1_pv_ff[i] <= n2_vec[i] * n2_eye[i];
            c1_pn_ff[i] <= n2_n[i] * n2_eye[i];
         end

         c2_deg_ff   <= c1_deg_ff;
         c2_eye_ff   <= c1_eye_ff;
         c2_n_ff     <= c1_n_ff;
         c2_v_vec_ff <= c1_v_vec_ff;
         for (int i = 0; i < 3; i++)
            c2_w_ff[i] <= clamp_unit(rnd(RW'(c1_cx_ff[2*i]) - RW'(c1_cx_ff[2*i+1])));
         c2_accv_ff <= RW'(c1_pv_ff[0]) + RW'(c1_pv_ff[1]) + RW'(c1_pv_ff[2]);
         c2_accn_ff <= RW'(c1_pn_ff[0]) + RW'(c1_pn_ff[1]) + RW'(c1_pn_ff[2]);

         c3_deg_ff   <= c2_deg_ff;
         c3_n_ff     <= c2_n_ff;
         c3_v_vec_ff <= c2_v_vec_ff;
         c3_w_ff     <= c2_w_ff;
         for (int i = 0; i < 3; i++) c3_pw_ff[i] <= c2_w_ff[i] * c2_eye_ff[i];
         c3_offv_ff <= sat_off(-rnd(c2_accv_ff));
         c3_offn_ff <= sat_off(rnd(c2_accn_ff));

         c4_deg_ff   <= c3_deg_ff;
         c4_n_ff     <= c3_n_ff;
         c4_v_vec_ff <= c3_v_vec_ff;
         c4_w_ff     <= c3_w_ff;
         c4_accw_ff  <= RW'(c3_pw_ff[0]) + RW'(c3_pw_ff[1]) + RW'(c3_pw_ff[2]);
         c4_offv_ff  <= c3_offv_ff;
         c4_offn_ff  <= c3_offn_ff;

         c5_deg_ff   <= c4_deg_ff;
         c5_n_ff     <= c4_n_ff;
         c5_v_vec_ff <= c4_v_vec_ff;
         c5_w_ff     <= c4_w_ff;
         c5_offw_ff  <= sat_off(-rnd(c4_accw_ff));
         c5_offv_ff  <= c4_offv_ff;
         c5_offn_ff  <= c4_offn_ff;
      end
   end

   // serializer control: right, up, then negated view row
   always_ff @(posedge clock) begin
      if (reset) begin
         o_full_ff <= 1'b0;
         o_row_ff  <= ROW_RIGHT;
      end else if (o_load) begin
         o_full_ff <= 1'b1;
         o_row_ff  <= ROW_RIGHT;
      end else if (rsp_take) begin
         case (o_row_ff)
            ROW_RIGHT: o_row_ff <= ROW_UP;
            ROW_UP:    o_row_ff <= ROW_VIEW;
            default: begin
               o_row_ff  <= ROW_RIGHT;
               o_full_ff <= 1'b0;
            end
         endcase
      end
   end

   // degenerate words carry zero axes and offsets on every row
   always_ff @(posedge clock) begin
      if (o_load) begin
         o_deg_ff <= c5_deg_ff;
         for (int i = 0; i < 3; i++) begin
            o_ax_ff[0][i] <= c5_deg_ff ? '0 : c5_w_ff[i];
            o_ax_ff[1][i] <= c5_deg_ff ? '0 : c5_v_vec_ff[i];
            o_ax_ff[2][i] <= c5_deg_ff ? '0 : -c5_n_ff[i];
         end
         o_off_ff[0] <= c5_deg_ff ? '0 : c5_offw_ff;
         o_off_ff[1] <= c5_deg_ff ? '0 : c5_offv_ff;
         o_off_ff[2] <= c5_deg_ff ? '0 : c5_offn_ff;
      end
   end

   always_comb begin
      case (o_row_ff)
         ROW_RIGHT: begin
            rsp_axis_x = o_ax_ff[0][0];
            rsp_axis_y = o_ax_ff[0][1];
            rsp_axis_z = o_ax_ff[0][2];
            rsp_offset = o_off_ff[0];
         end
         ROW_UP: begin
            rsp_axis_x = o_ax_ff[1][0];
            rsp_axis_y = o_ax_ff[1][1];
            rsp_axis_z = o_ax_ff[1][2];
            rsp_offset = o_off_ff[1];
         end
         default: begin
            rsp_axis_x = o_ax_ff[2][0];
            rsp_axis_y = o_ax_ff[2][1];
            rsp_axis_z = o_ax_ff[2][2];
            rsp_offset = o_off_ff[2];
         end
      endcase
   end

   assign rsp_valid      = o_full_ff;
   assign rsp_row_index  = o_row_ff;
   assign rsp_degenerate = o_deg_ff;
   assign rsp_last_row   = (o_row_ff == ROW_VIEW);

endmodule

[hw/rtl/lvm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_checker
// port-level checks on the row stream of the look-at view matrix unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lvm_checker
   import lvm_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [1:0]              rsp_row_index,
   input logic signed [AX_W-1:0]  rsp_axis_x,
   input logic signed [AX_W-1:0]  rsp_axis_y,
   input logic signed [AX_W-1:0]  rsp_axis_z,
   input logic signed [OFF_W-1:0] rsp_offset,
   input logic                    rsp_degenerate,
   input logic                    rsp_last_row
);

   `LVM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_row_index) && $stable(rsp_offset))
   `LVM_ASSERT_NEXT(a_row_follows, clock, reset, rsp_valid && !rsp_stall && !rsp_last_row, rsp_valid && rsp_row_index == $past(rsp_row_index) + 2'd1 && rsp_degenerate == $past(rsp_degenerate))
   `LVM_ASSERT_NOW(a_last_marks_view, clock, reset, rsp_valid, rsp_last_row == (rsp_row_index == ROW_VIEW))
   `LVM_ASSERT_NOW(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate, rsp_axis_x == '0 && rsp_axis_y == '0 && rsp_axis_z == '0 && rsp_offset == '0)

endmodule

bind look_at_view_matrix lvm_checker u_lvm_checker (.*);
